/* rtl/mmre_pkg.sv */
// Package for the matrix multiply row engine.
// Field widths, request mode codes and the issue tag passed from sequencer to MAC.
// No dependencies.
`default_nettype none
package mmre_pkg;

  localparam int DIM_DEF = 16;

  localparam int IDX_W = 4;   // row / col fields
  localparam int VAL_W = 16;  // Q8.8 element
  localparam int PRD_W = 32;  // Q16.16 product
  localparam int ACC_W = 40;  // Q24.16 sum

  localparam logic [1:0] MODE_WR_A = 2'd0;
  localparam logic [1:0] MODE_WR_B = 2'd1;
  localparam logic [1:0] MODE_CALC = 2'd2;

  typedef struct packed {
    logic             valid;
    logic             first;     // k == 0, restart the sum
    logic             last_k;    // k == DIM-1, sum complete
    logic [IDX_W-1:0] col;
    logic             last_col;  // final column of the row
  } mac_tag_t;

endpackage
`default_nettype wire

/* rtl/mmre_ram.sv */
// Single write port, single read port element store with registered read data.
// Depends on nothing; widths come from parameters.
`default_nettype none
module mmre_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/mmre_seq.sv */
// Request decode and compute sequencer: walks columns and k, issues store
// addresses and MAC tags. Uses mmre_pkg.
`default_nettype none
module mmre_seq
  import mmre_pkg::*;
#(
  parameter int DIM = DIM_DEF,
  localparam int AW = $clog2(DIM * DIM)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [1:0]       in_mode,
  input  wire logic [IDX_W-1:0] in_row,
  input  wire logic [IDX_W-1:0] in_col,
  output logic                  busy,
  output logic                  wr_a_en,
  output logic                  wr_b_en,
  output logic      [AW-1:0]    wr_addr,
  output logic      [AW-1:0]    rd_a_addr,
  output logic      [AW-1:0]    rd_b_addr,
  output mac_tag_t              tag,
  input  wire logic             row_done
);

  localparam int CW = $clog2(DIM);
  localparam logic [CW-1:0] CNT_LAST = CW'(DIM - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  logic [CW-1:0]    c_r, c_nxt;

  logic accept;
  logic row_ok;
  logic col_ok;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign row_ok = (32'(in_row) < DIM);
  assign col_ok = (32'(in_col) < DIM);

  assign wr_a_en = accept && (in_mode == MODE_WR_A) && row_ok && col_ok;
  assign wr_b_en = accept && (in_mode == MODE_WR_B) && row_ok && col_ok;
  assign wr_addr = AW'(32'(in_row) * DIM + 32'(in_col));

  assign rd_a_addr = AW'(32'(row_r) * DIM + 32'(k_r));
  assign rd_b_addr = AW'(32'(k_r) * DIM + 32'(c_r));

  always_comb begin
    tag.valid    = (state_r == S_RUN);
    tag.first    = (k_r == '0);
    tag.last_k   = (k_r == CNT_LAST);
    tag.col      = IDX_W'(c_r);
    tag.last_col = (c_r == CNT_LAST);
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    k_nxt     = k_r;
    c_nxt     = c_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_mode == MODE_CALC) && row_ok) begin
          state_nxt = S_RUN;
          row_nxt   = in_row;
          k_nxt     = '0;
          c_nxt     = '0;
        end
      end
      S_RUN: begin
        if (k_r == CNT_LAST) begin
          k_nxt = '0;
          if (c_r == CNT_LAST) begin
            state_nxt = S_DRAIN;
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DRAIN: begin
        // final sum is written at the edge where row_done ends this state
        if (row_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    row_r <= row_nxt;
    k_r   <= k_nxt;
    c_r   <= c_nxt;
  end

endmodule
`default_nettype wire

/* rtl/mmre_mac.sv */
// Shared multiply-accumulate pipeline: tag align, product register, accumulator
// and result strobe. Uses mmre_pkg.
`default_nettype none
module mmre_mac
  import mmre_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mac_tag_t                tag_in,
  input  wire logic signed [VAL_W-1:0] a_data,
  input  wire logic signed [VAL_W-1:0] b_data,
  output logic                         row_done,
  output logic                         out_strobe,
  output logic             [IDX_W-1:0] out_col,
  output logic signed      [ACC_W-1:0] out_value,
  output logic                         out_last
);

  mac_tag_t                tag_s1_r;  // aligned with store read data
  mac_tag_t                tag_s2_r;  // aligned with product
  logic signed [PRD_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic                    strobe_r;
  logic        [IDX_W-1:0] col_r;
  logic                    last_r;

  assign acc_nxt = (tag_s2_r.first ? '0 : acc_r)
                 + {{(ACC_W - PRD_W){prod_r[PRD_W-1]}}, prod_r};

  assign row_done = tag_s2_r.valid && tag_s2_r.last_k && tag_s2_r.last_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_s1_r.valid <= 1'b0;
      tag_s2_r.valid <= 1'b0;
      strobe_r       <= 1'b0;
    end else begin
      tag_s1_r.valid <= tag_in.valid;
      tag_s2_r.valid <= tag_s1_r.valid;
      strobe_r       <= tag_s2_r.valid && tag_s2_r.last_k;
    end
    tag_s1_r.first    <= tag_in.first;
    tag_s1_r.last_k   <= tag_in.last_k;
    tag_s1_r.col      <= tag_in.col;
    tag_s1_r.last_col <= tag_in.last_col;
    tag_s2_r.first    <= tag_s1_r.first;
    tag_s2_r.last_k   <= tag_s1_r.last_k;
    tag_s2_r.col      <= tag_s1_r.col;
    tag_s2_r.last_col <= tag_s1_r.last_col;
    prod_r <= PRD_W'(a_data) * PRD_W'(b_data);
    if (tag_s2_r.valid) begin
      acc_r  <= acc_nxt;
      col_r  <= tag_s2_r.col;
      last_r <= tag_s2_r.last_col;
    end
  end

  assign out_strobe = strobe_r;
  assign out_col    = col_r;
  assign out_value  = acc_r;
  assign out_last   = last_r;

endmodule
`default_nettype wire

/* rtl/matrix_multiply_row_engine.sv */
// Top level of the matrix multiply row engine: A/B element stores, sequencer
// and MAC pipeline. Uses mmre_pkg, mmre_ram, mmre_seq, mmre_mac.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  request  | start & !busy          | in_mode, in_row, in_col, in_value
//  result   | out_strobe (one cycle) | out_col, out_value, out_last
//
// A store write is taken while busy stays low.
// A compute request holds busy while the sequencer runs: one product per cycle
// through the single multiplier, then a drain while the last product passes
// store read and multiply. Results appear one per column; the last one
// strobes in the same cycle that busy drops.
// Synchronous active-low reset clears control only; stores are undefined.
// Results cannot be stalled; each strobe lasts exactly one cycle.
`default_nettype none
module matrix_multiply_row_engine
  import mmre_pkg::*;
#(
  parameter int DIM = DIM_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic             [1:0]  in_mode,
  input  wire logic       [IDX_W-1:0]  in_row,
  input  wire logic       [IDX_W-1:0]  in_col,
  input  wire logic signed [VAL_W-1:0] in_value,
  output logic                         out_strobe,
  output logic            [IDX_W-1:0]  out_col,
  output logic signed     [ACC_W-1:0]  out_value,
  output logic                         out_last
);

  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);

  logic             wr_a_en;
  logic             wr_b_en;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_a_addr;
  logic [AW-1:0]    rd_b_addr;
  logic [VAL_W-1:0] a_data;
  logic [VAL_W-1:0] b_data;
  mac_tag_t         tag;
  logic             row_done;

  mmre_seq #(
    .DIM (DIM)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_mode),
    .in_row    (in_row),
    .in_col    (in_col),
    .busy      (busy),
    .wr_a_en   (wr_a_en),
    .wr_b_en   (wr_b_en),
    .wr_addr   (wr_addr),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .tag       (tag),
    .row_done  (row_done)
  );

  mmre_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VAL_W)
  ) u_a_store (
    .clk     (clk),
    .we      (wr_a_en),
    .waddr   (wr_addr),
    .wdata   (in_value),
    .raddr   (rd_a_addr),
    .rdata_r (a_data)
  );

  mmre_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VAL_W)
  ) u_b_store (
    .clk     (clk),
    .we      (wr_b_en),
    .waddr   (wr_addr),
    .wdata   (in_value),
    .raddr   (rd_b_addr),
    .rdata_r (b_data)
  );

  mmre_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .tag_in     (tag),
    .a_data     (a_data),
    .b_data     (b_data),
    .row_done   (row_done),
    .out_strobe (out_strobe),
    .out_col    (out_col),
    .out_value  (out_value),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire

/* verif/tb_matrix_multiply_row_engine.sv */
// Self-checking bench for matrix_multiply_row_engine: loads A and B, requests result rows
// and checks every emitted element against a Q24.16 row product kept alongside.
// Depends on mmre_pkg and the RTL of the row engine.
module tb_matrix_multiply_row_engine
  import mmre_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N = DIM_DEF;
  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 8;
  localparam int RAND_ITEMS = 380;
  localparam int MAX_GAP = 19;
  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES = N * N + 16;

  localparam logic [1:0] MODE_NONE = 2'd3;  // unused code, block drops the request
  localparam logic signed [VAL_W-1:0] Q_MIN = 16'sh8000;
  localparam logic signed [VAL_W-1:0] Q_MAX = 16'sh7FFF;
  localparam logic signed [VAL_W-1:0] Q_ZERO = 16'sh0000;
  localparam logic signed [VAL_W-1:0] Q_NEG_LSB = 16'shFFFF;

  typedef struct {
    logic [IDX_W-1:0]        col;
    logic signed [ACC_W-1:0] value;
    logic                    last;
  } row_elem_t;

  // Shadow copy of both stores plus the result elements still owed by the block.
  class matmul_rows;
    logic signed [VAL_W-1:0] a_elem [N][N];
    logic signed [VAL_W-1:0] b_elem [N][N];
    row_elem_t               due_elems [$];
    int                      mismatches;

    function void take_request(logic [1:0] mode, logic [IDX_W-1:0] row,
                               logic [IDX_W-1:0] col, logic signed [VAL_W-1:0] value);
      longint    acc;
      row_elem_t e;
      case (mode)
        MODE_WR_A: a_elem[row][col] = value;
        MODE_WR_B: b_elem[row][col] = value;
        MODE_CALC: begin
          for (int c = 0; c < N; c++) begin
            acc = 0;
            for (int k = 0; k < N; k++)
              acc += longint'(a_elem[row][k]) * longint'(b_elem[k][c]);
            e.col = IDX_W'(c);
            e.value = acc[ACC_W-1:0];
            e.last = (c == N - 1);
            due_elems.push_back(e);
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string what, longint exp_v, longint act_v);
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, what, exp_v, act_v);
    endfunction

    function void match_element(logic [IDX_W-1:0] col, logic signed [ACC_W-1:0] value,
                                logic last);
      row_elem_t e;
      if (due_elems.size() == 0) begin
        mismatches++;
        $display("%0t: result col %0d value %0d with nothing pending", $time, col, value);
        return;
      end
      e = due_elems.pop_front();
      if (col !== e.col) report("out_col", e.col, col);
      if (value !== e.value) report("out_value", e.value, value);
      if (last !== e.last) report("out_last", e.last, last);
    endfunction

    function int pending();
      return due_elems.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [1:0]               in_mode;
  logic [IDX_W-1:0]         in_row;
  logic [IDX_W-1:0]         in_col;
  logic signed [VAL_W-1:0]  in_value;
  logic                     out_strobe;
  logic [IDX_W-1:0]         out_col;
  logic signed [ACC_W-1:0]  out_value;
  logic                     out_last;

  matmul_rows product_rows = new();
  bit a_set [N][N];
  bit b_set [N][N];
  bit gapless;
  int req_count;
  int cycle_cnt;

  matrix_multiply_row_engine #(.DIM(N)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_mode    (in_mode),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_value   (in_value),
    .out_strobe (out_strobe),
    .out_col    (out_col),
    .out_value  (out_value),
    .out_last   (out_last)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1)
      product_rows.match_element(out_col, out_value, out_last);
  end

  // start stays high when the next request follows with no gap
  task automatic issue_req(input logic [1:0] mode, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic signed [VAL_W-1:0] value);
    int gap;
    start <= 1'b1;
    in_mode <= mode;
    in_row <= row;
    in_col <= col;
    in_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
    product_rows.take_request(mode, row, col, value);
    if (mode == MODE_WR_A) a_set[row][col] = 1'b1;
    if (mode == MODE_WR_B) b_set[row][col] = 1'b1;
    if (mode != MODE_NONE) req_count++;
    gap = gapless ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // always spends at least one edge, so start is never driven twice in one step
  task automatic drain_rows();
    start <= 1'b0;
    do @(posedge clk); while (product_rows.pending() != 0);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return Q_ZERO;
      3: return Q_NEG_LSB;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // store write, now and then preceded by a request the block drops
  task automatic write_elem(input logic [1:0] mode, input int r, input int c,
                            input logic signed [VAL_W-1:0] v);
    if ($urandom_range(0, 11) == 0)
      issue_req(MODE_NONE, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
    issue_req(mode, IDX_W'(r), IDX_W'(c), v);
  endtask

  task automatic load_a_row(input int r, input bit fixed, input logic signed [VAL_W-1:0] v);
    int order [N];
    int j;
    int t;
    for (int i = 0; i < N; i++) order[i] = i;
    for (int i = N - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < N; i++)
      write_elem(MODE_WR_A, r, order[i], fixed ? v : pick_value());
  endtask

  task automatic fill_b();
    int order [N*N];
    int j;
    int t;
    for (int i = 0; i < N * N; i++) order[i] = i;
    for (int i = N * N - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < N * N; i++)
      write_elem(MODE_WR_B, order[i] / N, order[i] % N, pick_value());
  endtask

  // col and value are don't-care on a compute request, so they get noise
  task automatic calc_row(input int r);
    issue_req(MODE_CALC, IDX_W'(r), IDX_W'($urandom), VAL_W'($urandom));
  endtask

  // one column of the row sees N identical products: largest sums in both signs
  task automatic corner_row(input logic signed [VAL_W-1:0] a_v,
                            input logic signed [VAL_W-1:0] b_v);
    int r;
    int c;
    r = $urandom_range(0, N - 1);
    c = $urandom_range(0, N - 1);
    load_a_row(r, 1'b1, a_v);
    for (int k = 0; k < N; k++) write_elem(MODE_WR_B, k, c, b_v);
    calc_row(r);
  endtask

  function automatic bit row_ready(int r);
    for (int k = 0; k < N; k++)
      if (!a_set[r][k]) return 1'b0;
    for (int i = 0; i < N; i++)
      for (int k = 0; k < N; k++)
        if (!b_set[i][k]) return 1'b0;
    return 1'b1;
  endfunction

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int ready_rows [$];
    int kind;
    int r;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= MODE_WR_A;
    in_row <= '0;
    in_col <= '0;
    in_value <= '0;
    gapless = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: dropped mode, index corners, value extremes
    issue_req(MODE_NONE, '1, '1, Q_NEG_LSB);
    issue_req(MODE_NONE, '0, '0, Q_ZERO);
    issue_req(MODE_WR_A, '0, '0, Q_MIN);
    issue_req(MODE_WR_A, '1, '1, Q_MAX);
    issue_req(MODE_WR_A, '0, '1, Q_NEG_LSB);
    issue_req(MODE_WR_B, '1, '0, Q_MIN);
    issue_req(MODE_WR_B, '0, '1, Q_MAX);
    issue_req(MODE_WR_B, '1, '1, Q_ZERO);

    req_count = 0;
    fill_b();
    gapless = 1'b1;
    load_a_row(0, 1'b0, Q_ZERO);
    gapless = 1'b0;
    load_a_row(N - 1, 1'b0, Q_ZERO);
    calc_row(0);
    calc_row(N - 1);
    drain_rows();
    corner_row(Q_MIN, Q_MIN);
    corner_row(Q_MAX, Q_MIN);

    while (req_count < RAND_ITEMS) begin
      gapless = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) drain_rows();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        corner_row($urandom_range(0, 1) ? Q_MAX : Q_MIN, $urandom_range(0, 1) ? Q_MAX : Q_MIN);
      end else if (kind <= 3) begin
        ready_rows = {};
        for (int i = 0; i < N; i++)
          if (row_ready(i)) ready_rows.push_back(i);
        calc_row(ready_rows[$urandom_range(0, ready_rows.size() - 1)]);
      end else begin
        repeat ($urandom_range(0, 5))
          write_elem($urandom_range(0, 1) ? MODE_WR_B : MODE_WR_A,
                     $urandom_range(0, N - 1), $urandom_range(0, N - 1), pick_value());
        r = $urandom_range(0, N - 1);
        load_a_row(r, 1'b0, Q_ZERO);
        calc_row(r);
      end
    end

    drain_rows();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (product_rows.mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

/* files.f */
rtl/mmre_pkg.sv
rtl/mmre_ram.sv
rtl/mmre_seq.sv
rtl/mmre_mac.sv
rtl/matrix_multiply_row_engine.sv
verif/tb_matrix_multiply_row_engine.sv
